@@ rtl/core/iset_pkg.sv @@
// Shared constants, operation codes and cell control type for the integer set.
`default_nettype none

package iset_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int OUT_CNT_W = 7;

  localparam logic [1:0] OP_ADD      = 2'd0;
  localparam logic [1:0] OP_REMOVE   = 2'd1;
  localparam logic [1:0] OP_CONTAINS = 2'd2;
  localparam logic [1:0] OP_CLEAR    = 2'd3;

  typedef struct packed {
    logic cmp_en;
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/core/iset_cell.sv @@
// One slot of the set: holds a member, compares it and takes its neighbour's on compaction.
`default_nettype none

module iset_cell
  import iset_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cell_ctrl_t        ctrl,
  input  wire logic [DATA_W-1:0] value,
  input  wire logic [DATA_W-1:0] next_entry,
  input  wire logic              in_range,
  output logic [DATA_W-1:0]      entry,
  output logic                   match
);

  logic [DATA_W-1:0] entry_r;
  logic              match_r;

  // Append a new member, or pull the upper neighbour down on remove
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      entry_r <= value;
    end else if (ctrl.shift) begin
      entry_r <= next_entry;
    end
  end

  // Register the comparison against the request value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else if (ctrl.cmp_en) begin
      match_r <= in_range && (entry_r == value);
    end
  end

  assign entry = entry_r;
  assign match = match_r;

endmodule

`default_nettype wire

@@ rtl/core/insertion_ordered_int_set.sv @@
// Each item passes the steps accept, cell compare, and reduce and update; the result is
// registered on update. A new item is accepted only once the last one has updated, and
// the update waits while a finished result is held by out_stall.
// Reset (rst_n low, synchronous): member count goes to zero and no result is pending;
// slot contents are not cleared and are never read above the count.
`default_nettype none

module insertion_ordered_int_set
  import iset_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [1:0]               in_req_type,
  input  wire logic signed [DATA_W-1:0] in_value,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic                          out_success,
  output logic                          out_full_res,
  output logic [OUT_CNT_W-1:0]          out_count
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;

  logic [1:0]           state_r, state_nxt;
  logic [1:0]           op_r;
  logic [DATA_W-1:0]    value_r;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 out_valid_r;
  logic                 out_success_r;
  logic                 out_full_r;
  logic [OUT_CNT_W-1:0] out_count_r;

  logic [CAPACITY-1:0]  match_vec;
  logic [CAPACITY-1:0]  prefix_vec;
  logic [CAPACITY-1:0]  range_vec;
  logic [DATA_W-1:0]    entry_vec [CAPACITY];
  cell_ctrl_t           ctrl_vec  [CAPACITY];

  logic found;
  logic not_full;
  logic add_ok;
  logic rem_ok;
  logic upd_go;
  logic accept;
  logic success_nxt;
  logic full_nxt;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign upd_go   = (state_r == ST_UPD) && (!out_valid_r || !out_stall);

  assign found    = |match_vec;
  assign not_full = (count_r < CNT_W'(CAPACITY));
  assign add_ok   = (op_r == OP_ADD) && !found && not_full;
  assign rem_ok   = (op_r == OP_REMOVE) && found;

  // Build the row of cells with their per-slot control
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] nb_entry;

    if (i == CAPACITY - 1) begin : g_last
      assign nb_entry = entry_vec[i];
    end else begin : g_mid
      assign nb_entry = entry_vec[i+1];
    end

    assign range_vec[i]      = (CNT_W'(i) < count_r);
    assign prefix_vec[i]     = |match_vec[i:0];
    assign ctrl_vec[i].cmp_en = (state_r == ST_CMP);
    assign ctrl_vec[i].load  = upd_go && add_ok && (count_r == CNT_W'(i));
    assign ctrl_vec[i].shift = upd_go && rem_ok && prefix_vec[i];

    iset_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl_vec[i]),
      .value      (value_r),
      .next_entry (nb_entry),
      .in_range   (range_vec[i]),
      .entry      (entry_vec[i]),
      .match      (match_vec[i])
    );
  end

  // Decide the result and the new count
  always_comb begin
    count_nxt   = count_r;
    success_nxt = 1'b0;
    full_nxt    = 1'b0;
    unique case (op_r)
      OP_ADD: begin
        success_nxt = add_ok;
        full_nxt    = !found && !not_full;
        if (add_ok) begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        success_nxt = rem_ok;
        if (rem_ok) begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
      OP_CONTAINS: begin
        success_nxt = found;
      end
      default: begin
        count_nxt   = '0;
        success_nxt = 1'b1;
      end
    endcase
  end

  // Sequence accept, compare and update
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: state_nxt = ST_UPD;
      ST_UPD: begin
        if (upd_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (upd_go) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Capture the request and the result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_req_type;
      value_r <= in_value;
    end
    if (upd_go) begin
      out_success_r <= success_nxt;
      out_full_r    <= full_nxt;
      out_count_r   <= OUT_CNT_W'(count_nxt);
    end
  end

  assign out_valid    = out_valid_r;
  assign out_success  = out_success_r;
  assign out_full_res = out_full_r;
  assign out_count    = out_count_r;

endmodule

`default_nettype wire

@@ bench/iset_result_checker.sv @@
// Result checker for the integer set: predicts each result from accepted items and compares.
module iset_result_checker
  import iset_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [1:0]        in_req_type,
  input  logic [DATA_W-1:0] in_value,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic              out_success,
  input  logic              out_full_res,
  input  logic [OUT_CNT_W-1:0] out_count,
  output int                mismatch_total,
  output int                results_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic                 success;
    logic                 full_res;
    logic [OUT_CNT_W-1:0] count;
  } set_result_t;

  // Shadow copy of the set, packed from slot 0 in insertion order
  logic [DATA_W-1:0] member_slots [CAPACITY];
  int                member_total = 0;
  set_result_t       expected_results [$];

  initial begin
    mismatch_total  = 0;
    results_pending = 0;
  end

  // Apply one request to the shadow set and return the result it causes
  function automatic set_result_t apply_request(logic [1:0] op, logic [DATA_W-1:0] val);
    set_result_t r;
    int          hit;
    r   = '0;
    hit = -1;
    for (int i = 0; i < member_total; i++) begin
      if (hit < 0 && member_slots[i] == val) hit = i;
    end
    case (op)
      OP_ADD: begin
        if (hit < 0) begin
          if (member_total >= CAPACITY) begin
            r.full_res = 1'b1;
          end else begin
            member_slots[member_total] = val;
            member_total++;
            r.success = 1'b1;
          end
        end
      end
      OP_REMOVE: begin
        if (hit >= 0) begin
          // close the gap by shifting later members down one slot
          for (int i = hit; i + 1 < member_total; i++) member_slots[i] = member_slots[i + 1];
          member_total--;
          r.success = 1'b1;
        end
      end
      OP_CONTAINS: begin
        r.success = (hit >= 0);
      end
      default: begin
        member_total = 0;
        r.success    = 1'b1;
      end
    endcase
    r.count = member_total[OUT_CNT_W-1:0];
    return r;
  endfunction

  // Count a failure, report only the first few
  task automatic note_failure(string msg);
    mismatch_total++;
    if (mismatch_total <= MAX_REPORTS) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // Compare the accepted result first, then queue the prediction for the accepted item
  always @(posedge clk) begin
    set_result_t got;
    set_result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got.success  = out_success;
        got.full_res = out_full_res;
        got.count    = out_count;
        if (expected_results.size() == 0) begin
          note_failure($sformatf("result with none pending: success=%0b full=%0b count=%0d",
                                 got.success, got.full_res, got.count));
        end else begin
          want = expected_results.pop_front();
          if (got.success !== want.success || got.full_res !== want.full_res ||
              got.count !== want.count) begin
            note_failure($sformatf(
              "expected success=%0b full=%0b count=%0d, got success=%0b full=%0b count=%0d",
              want.success, want.full_res, want.count,
              got.success, got.full_res, got.count));
          end
        end
      end
      if (in_valid && !in_stall) expected_results.push_back(apply_request(in_req_type, in_value));
      results_pending = expected_results.size();
    end
  end

endmodule

@@ bench/tb_top.sv @@
// Top of the integer set testbench: clock, reset, request stimulus, result stalls and verdict.
module tb_top;
  import iset_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD  = 10;
  localparam int ITEMS_TOTAL = 1050;
  localparam int FINAL_ITEMS = 150;
  localparam int LONG_HOLD   = 80;
  localparam int DRAIN_WAIT  = 10;
  localparam int IDLE_LIMIT  = 2000;

  typedef enum int {MIX_FILL, MIX_CHURN, MIX_DENSE, MIX_NOISE} traffic_mix_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        in_req_type = OP_ADD;
  logic [DATA_W-1:0] in_value = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_success;
  logic              out_full_res;
  logic [OUT_CNT_W-1:0] out_count;

  int mismatch_total;
  int results_pending;

  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  bit long_hold_req = 1'b0;
  int stall_left = 0;
  int items_sent = 0;
  int quiet_cycles = 0;

  logic [DATA_W-1:0] value_pool [128];
  int                pool_size = 1;

  // Directed items: empty set, extremes, duplicate, compaction at first, middle and last position, clear
  logic [1:0] directed_op [22] = '{
    OP_CONTAINS, OP_REMOVE, OP_ADD, OP_ADD, OP_ADD, OP_ADD, OP_ADD, OP_CONTAINS,
    OP_CONTAINS, OP_REMOVE, OP_CONTAINS, OP_REMOVE, OP_REMOVE, OP_REMOVE, OP_ADD, OP_ADD,
    OP_CLEAR, OP_CONTAINS, OP_REMOVE, OP_ADD, OP_CLEAR, OP_CLEAR};
  logic [DATA_W-1:0] directed_val [22] = '{
    32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
    32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'h0000_0000, 32'hffff_ffff, 32'h8000_0000,
    32'hffff_ffff, 32'h1234_5678, 32'h5555_5555, 32'haaaa_aaaa, 32'h0000_0000, 32'h7fff_ffff,
    32'h5555_5555, 32'h7fff_ffff, 32'hdead_beef, 32'h0000_0000};

  always #(CLK_PERIOD / 2) clk = ~clk;

  insertion_ordered_int_set dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_req_type  (in_req_type),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_success  (out_success),
    .out_full_res (out_full_res),
    .out_count    (out_count)
  );

  iset_result_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_success     (out_success),
    .out_full_res    (out_full_res),
    .out_count       (out_count),
    .mismatch_total  (mismatch_total),
    .results_pending (results_pending)
  );

  // Stall the result channel: long hold on request, otherwise random bursts
  always @(negedge clk) begin
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      stall_left    = LONG_HOLD;
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
      out_stall  <= 1'b1;
      stall_left = $urandom_range(0, 6);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // End the run when neither channel moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Offer one request, after an optional idle burst, and hold it until accepted
  task automatic send_request(input logic [1:0] op, input logic [DATA_W-1:0] val);
    int gap;
    gap = 0;
    if (tx_idle_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 7);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= op;
    in_value    <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic wait_for_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  // Fill the value pool with random words, extremes and small signed numbers
  task automatic build_pool(input int n);
    int r;
    pool_size = n;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 9);
      case (r)
        0:       value_pool[i] = 32'h8000_0000;
        1:       value_pool[i] = 32'h7fff_ffff;
        2:       value_pool[i] = DATA_W'($signed($urandom_range(0, 31)) - 16);
        default: value_pool[i] = $urandom;
      endcase
    end
  endtask

  function automatic logic [1:0] pick_op(traffic_mix_t mix);
    int r;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  return (r < 85) ? OP_ADD : OP_CONTAINS;
      MIX_CHURN: return (r < 40) ? OP_ADD : (r < 70) ? OP_REMOVE : (r < 97) ? OP_CONTAINS : OP_CLEAR;
      MIX_DENSE: return (r < 35) ? OP_ADD : (r < 65) ? OP_REMOVE : (r < 92) ? OP_CONTAINS : OP_CLEAR;
      default:   return 2'($urandom_range(0, 3));
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_value(traffic_mix_t mix);
    int r;
    r = $urandom_range(0, 99);
    if ((mix == MIX_NOISE && r < 70) || (mix == MIX_CHURN && r < 10)) return $urandom;
    return value_pool[$urandom_range(0, pool_size - 1)];
  endfunction

  // Run a stretch of traffic of one mix, with pool size to suit it
  task automatic run_phase(input traffic_mix_t mix, input int n_items);
    logic [1:0] op;
    case (mix)
      MIX_FILL:  build_pool(80);
      MIX_CHURN: build_pool(24);
      MIX_DENSE: build_pool(6);
      default:   build_pool(16);
    endcase
    for (int i = 0; i < n_items; i++) begin
      op = pick_op(mix);
      send_request(op, pick_value(mix));
    end
  endtask

  initial begin
    traffic_mix_t mix;
    int           len;
    bit           hold_done;
    bit           pause_done;
    hold_done  = 1'b0;
    pause_done = 1'b0;

    // Hold reset low, then release it at a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed items
    for (int i = 0; i < 22; i++) send_request(directed_op[i], directed_val[i]);

    // Fill to capacity first so refused adds come early
    run_phase(MIX_FILL, 200);

    // Random phases, with idling toggled per phase
    while (items_sent < ITEMS_TOTAL - FINAL_ITEMS) begin
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      if (!hold_done && items_sent >= 450) begin
        // hold off the receiver while the sender keeps offering items
        hold_done     = 1'b1;
        tx_idle_on    = 1'b0;
        long_hold_req = 1'b1;
        run_phase(MIX_CHURN, 30);
      end else if (!pause_done && items_sent >= 700) begin
        pause_done = 1'b1;
        wait_for_drain();
      end else begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4:              begin mix = MIX_FILL;  len = 200; end
          5, 6, 7, 8, 9, 10, 11:      begin mix = MIX_CHURN; len = $urandom_range(40, 120); end
          12, 13, 14, 15, 16:         begin mix = MIX_DENSE; len = $urandom_range(30, 80); end
          default:                    begin mix = MIX_NOISE; len = $urandom_range(20, 60); end
        endcase
        // trim the stretch so the random part ends near its share of items
        if (len > ITEMS_TOTAL - FINAL_ITEMS - items_sent) begin
          len = ITEMS_TOTAL - FINAL_ITEMS - items_sent;
        end
        run_phase(mix, len);
        if ($urandom_range(0, 5) == 0) wait_for_drain();
      end
    end

    // Final stretch at full rate on both sides
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    run_phase(MIX_CHURN, FINAL_ITEMS);

    // Drain and settle, then give the verdict
    wait_for_drain();
    if (mismatch_total == 0 && results_pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
